### hw/rtl/satmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satmp_pkg
// Types and constants shared by the stop-at-target motion profile block:
// item and result beats, mode and opcode codes, register indexes and the
// step numbers of the bit-serial sequencer.
// ----------------------------------------------------------------------------
package satmp_pkg;

  localparam int Q_W   = 32;
  localparam int TS_W  = 17;
  localparam int CNT_W = 16;
  localparam int REG_W = 3;
  localparam int SEQ_W = 6;

  localparam logic [1:0] MODE_ACC  = 2'd0;
  localparam logic [1:0] MODE_DEC  = 2'd1;
  localparam logic [1:0] MODE_CON  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [REG_W-1:0] REG_ACC_RATE    = 3'd0;
  localparam logic [REG_W-1:0] REG_DEC_RATE    = 3'd1;
  localparam logic [REG_W-1:0] REG_SPEED_LIMIT = 3'd2;
  localparam logic [REG_W-1:0] REG_TARGET_POS  = 3'd3;
  localparam logic [REG_W-1:0] REG_TIME_STEP   = 3'd4;
  localparam logic [REG_W-1:0] REG_STEP_COUNT  = 3'd5;

  // sequencer step numbers
  localparam logic [SEQ_W-1:0] SEQ_M1_LAST  = 6'd16;
  localparam logic [SEQ_W-1:0] SEQ_VNEW     = 6'd17;
  localparam logic [SEQ_W-1:0] SEQ_M2_LOAD  = 6'd18;
  localparam logic [SEQ_W-1:0] SEQ_M2_FIRST = 6'd19;
  localparam logic [SEQ_W-1:0] SEQ_SQ_LAST  = 6'd31;
  localparam logic [SEQ_W-1:0] SEQ_M2_LAST  = 6'd35;
  localparam logic [SEQ_W-1:0] SEQ_DONE     = 6'd36;

  typedef struct packed {
    logic            opcode;
    logic [1:0]      init_mode;
    logic [Q_W-1:0]  init_position;
    logic [Q_W-1:0]  init_speed;
    logic [Q_W-1:0]  init_accel;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      mode_out;
    logic [Q_W-1:0]  position_out;
    logic [Q_W-1:0]  speed_out;
    logic [Q_W-1:0]  accel_out;
    logic            last_step;
  } out_item_t;

endpackage

### hw/rtl/stop_at_target_motion_profile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_at_target_motion_profile
// Trapezoidal velocity profile generator in signed Q16.16 with bit-serial
// multipliers for the speed, position and stopping-distance arithmetic.
// ----------------------------------------------------------------------------
// A load beat sets mode, position, speed and acceleration and goes to the
// wait state, from which they move to the output register once it is free;
// the block then returns to idle, and a tick beat ends the same way. Beats
// are stalled outside idle. A tick runs one multiplier bit per cycle, where the
// 32-step square of the speed and the 32-step remaining-distance product run
// beside the 17-step speed product, which is followed by the 17-step
// position product that needs the new speed. The stop test compares
// remaining distance times twice the deceleration against speed squared, so
// no divider is used. A finished result sits in the output register while
// the next beat is accepted. Configuration writes are taken only while idle.
// ----------------------------------------------------------------------------
module stop_at_target_motion_profile (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  satmp_pkg::in_item_t                   item,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output satmp_pkg::out_item_t                  result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [satmp_pkg::REG_W-1:0]           cfg_index,
  input  logic [satmp_pkg::Q_W-1:0]             cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]                       state;
  logic [satmp_pkg::SEQ_W-1:0]      cnt;

  logic [31:0] acc_rate, dec_rate, speed_limit, target_position;
  logic [16:0] time_step;
  logic [15:0] step_count;

  logic [1:0]  mode_reg;
  logic [31:0] position_reg, speed_reg, accel_reg;
  logic [15:0] tick_counter;
  logic        last_flag;

  logic        rem_pos, dec_neg;
  logic [31:0] vnew;

  // speed product lane: accel * time_step
  logic [32:0] m1_hi, m1_sum;
  logic [16:0] m1_lo;
  // position product lane: (speed + vnew) * time_step
  logic [32:0] m2_a;
  logic [33:0] m2_hi, m2_sum;
  logic [16:0] m2_lo;
  // speed squared lane
  logic [31:0] sq_a;
  logic [32:0] sq_hi, sq_sum;
  logic [31:0] sq_lo;
  // remaining distance times twice the deceleration
  logic [32:0] rd_a;
  logic [33:0] rd_hi, rd_sum;
  logic [31:0] rd_lo;

  logic [49:0] m1_round;
  logic [50:0] m2_round;
  logic [34:0] v_sum, x_sum;
  logic [31:0] v_sat, x_sat;
  logic [32:0] remain, neg_dec;
  logic [31:0] mag;
  logic        stop_now, take_out, accept;
  logic [1:0]  mode_next, load_mode;
  logic [31:0] accel_next;
  logic [15:0] tick_inc;

  function automatic logic [31:0] sat32(input logic [34:0] s);
    logic [31:0] r;
    if (s[34:31] == 4'b0000 || s[34:31] == 4'b1111) begin
      r = s[31:0];
    end else if (s[34]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

  assign item_stall = (state != ST_IDLE);
  assign cfg_ready  = (state == ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign take_out   = !result_valid || !result_stall;

  always_comb begin
    m1_sum = m1_hi + (m1_lo[0] ? {accel_reg[31], accel_reg} : 33'd0);
    m2_sum = m2_hi + (m2_lo[0] ? {m2_a[32], m2_a} : 34'd0);
    sq_sum = sq_hi + (sq_lo[0] ? {1'b0, sq_a} : 33'd0);
    rd_sum = rd_hi + (rd_lo[0] ? {1'b0, rd_a} : 34'd0);

    m1_round = {m1_hi, m1_lo} + 50'd32768;
    m2_round = {m2_hi, m2_lo} + 51'd65536;
    v_sum = {{3{speed_reg[31]}}, speed_reg} + {m1_round[49], m1_round[49:16]};
    x_sum = {{3{position_reg[31]}}, position_reg} + {m2_round[50], m2_round[50:17]};
    v_sat = sat32(v_sum);
    x_sat = sat32(x_sum);

    remain  = {target_position[31], target_position} - {position_reg[31], position_reg};
    neg_dec = 33'd0 - {dec_rate[31], dec_rate};
    mag     = speed_reg[31] ? (32'd0 - speed_reg) : speed_reg;

    stop_now = !rem_pos || (dec_neg && ({rd_hi, rd_lo} <= {1'b0, sq_hi, sq_lo}));
    if (stop_now) begin
      mode_next = satmp_pkg::MODE_DEC;
    end else if (mode_reg == satmp_pkg::MODE_ACC &&
                 $signed(speed_reg) >= $signed(speed_limit)) begin
      mode_next = satmp_pkg::MODE_CON;
    end else begin
      mode_next = mode_reg;
    end

    case (mode_reg)
      satmp_pkg::MODE_ACC: accel_next = acc_rate;
      satmp_pkg::MODE_DEC: accel_next = dec_rate;
      default:             accel_next = 32'd0;
    endcase

    load_mode = (item.init_mode == satmp_pkg::MODE_NONE) ? satmp_pkg::MODE_CON
                                                         : item.init_mode;
    tick_inc  = tick_counter + 16'd1;
  end

  // control, configuration and profile state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      cnt             <= '0;
      result_valid    <= 1'b0;
      acc_rate        <= 32'd1310720;
      dec_rate        <= 32'hfff6_0000;
      speed_limit     <= 32'd1310720;
      target_position <= 32'd6553600;
      time_step       <= 17'd6554;
      step_count      <= 16'd100;
      mode_reg        <= satmp_pkg::MODE_ACC;
      position_reg    <= '0;
      speed_reg       <= '0;
      accel_reg       <= '0;
      tick_counter    <= '0;
      last_flag       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          satmp_pkg::REG_ACC_RATE:    acc_rate        <= cfg_data;
          satmp_pkg::REG_DEC_RATE:    dec_rate        <= cfg_data;
          satmp_pkg::REG_SPEED_LIMIT: speed_limit     <= cfg_data;
          satmp_pkg::REG_TARGET_POS:  target_position <= cfg_data;
          satmp_pkg::REG_TIME_STEP:   time_step       <= cfg_data[16:0];
          satmp_pkg::REG_STEP_COUNT:  step_count      <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (state == ST_WAIT && take_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept) begin
            if (item.opcode == satmp_pkg::OP_LOAD) begin
              mode_reg     <= load_mode;
              position_reg <= item.init_position;
              speed_reg    <= item.init_speed;
              accel_reg    <= item.init_accel;
              tick_counter <= '0;
              last_flag    <= 1'b0;
              state        <= ST_WAIT;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          cnt <= cnt + 6'd1;
          if (cnt == satmp_pkg::SEQ_DONE) begin
            mode_reg     <= mode_next;
            speed_reg    <= vnew;
            position_reg <= x_sat;
            accel_reg    <= accel_next;
            if (tick_counter != 16'hffff) begin
              tick_counter <= tick_inc;
              last_flag    <= (tick_inc == step_count);
            end else begin
              last_flag <= 1'b0;
            end
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (take_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // bit-serial datapath and result beat
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      m1_hi   <= '0;
      m1_lo   <= time_step;
      sq_a    <= mag;
      sq_hi   <= '0;
      sq_lo   <= mag;
      rd_a    <= {neg_dec[31:0], 1'b0};
      rd_hi   <= '0;
      rd_lo   <= remain[31:0];
      rem_pos <= !remain[32] && (remain != 33'd0);
      dec_neg <= dec_rate[31];
    end else if (state == ST_RUN) begin
      if (cnt <= satmp_pkg::SEQ_M1_LAST) begin
        m1_hi <= {m1_sum[32], m1_sum[32:1]};
        m1_lo <= {m1_sum[0], m1_lo[16:1]};
      end
      if (cnt <= satmp_pkg::SEQ_SQ_LAST) begin
        sq_hi <= {1'b0, sq_sum[32:1]};
        sq_lo <= {sq_sum[0], sq_lo[31:1]};
        rd_hi <= {1'b0, rd_sum[33:1]};
        rd_lo <= {rd_sum[0], rd_lo[31:1]};
      end
      if (cnt == satmp_pkg::SEQ_VNEW) begin
        vnew <= v_sat;
      end
      if (cnt == satmp_pkg::SEQ_M2_LOAD) begin
        m2_a  <= {speed_reg[31], speed_reg} + {vnew[31], vnew};
        m2_hi <= '0;
        m2_lo <= time_step;
      end
      if (cnt >= satmp_pkg::SEQ_M2_FIRST && cnt <= satmp_pkg::SEQ_M2_LAST) begin
        m2_hi <= {m2_sum[33], m2_sum[33:1]};
        m2_lo <= {m2_sum[0], m2_lo[16:1]};
      end
    end

    if (state == ST_WAIT && take_out) begin
      result.mode_out     <= mode_reg;
      result.position_out <= position_reg;
      result.speed_out    <= speed_reg;
      result.accel_out    <= accel_reg;
      result.last_step    <= last_flag;
    end
  end

`ifndef SYNTHESIS
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    mode_reg != satmp_pkg::MODE_NONE)
    else $error("mode register holds the unused code");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted beat did not start work");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && cnt == satmp_pkg::SEQ_DONE |=> state == ST_WAIT)
    else $error("sequencer did not finish at the last step");

  a_push: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT && take_out |=> result_valid && state == ST_IDLE)
    else $error("finished result not moved to the output register");

  a_last_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT && last_flag |-> tick_counter == step_count)
    else $error("last tick flag without matching count");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stop-at-target motion profile block. A short
// table of directed beats covers the state after reset, the field extremes,
// mode code three, saturation of speed and position, a zero and a positive
// deceleration, a time step above one and the tick-count flag. Random
// trajectories follow: a load and a run of ticks, a register set-up before
// every third one, with random loads and register sets mixed in. Both sides
// stall at random; the receiver holds off once for a long stretch, and the
// sender drains before each register set and once more. Each result beat is
// checked field by field against a pinned beat or the bench's bit-exact profile.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ITEMS       = 550;
  localparam int CALM_FROM   = 490;
  localparam int HOLD_CYCLES = 150;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 60;
  localparam logic [satmp_pkg::REG_W-1:0] REG_SPARE = 3'd7;
  localparam logic [satmp_pkg::Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [satmp_pkg::Q_W-1:0] Q_MIN = 32'h8000_0000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct {
    logic                 pinned;
    satmp_pkg::out_item_t want;
  } pin_t;

  typedef struct {
    logic                        is_reg;
    logic [satmp_pkg::REG_W-1:0] idx;
    logic [satmp_pkg::Q_W-1:0]   val;
    satmp_pkg::in_item_t         it;
    logic                        pinned;
    satmp_pkg::out_item_t        want;
  } plan_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        item_valid = 1'b0;
  logic                        item_stall;
  satmp_pkg::in_item_t         item = '0;
  logic                        result_valid;
  logic                        result_stall = 1'b0;
  satmp_pkg::out_item_t        result;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [satmp_pkg::REG_W-1:0] cfg_index = '0;
  logic [satmp_pkg::Q_W-1:0]   cfg_data = '0;

  // profile state and register shadow
  logic [1:0]         m_mode  = satmp_pkg::MODE_ACC;
  logic signed [31:0] m_pos   = '0;
  logic signed [31:0] m_spd   = '0;
  logic signed [31:0] m_acc   = '0;
  logic [15:0]        m_ticks = '0;
  logic signed [31:0] r_acc    = 32'sd1310720;
  logic signed [31:0] r_dec    = -32'sd655360;
  logic signed [31:0] r_vmax   = 32'sd1310720;
  logic signed [31:0] r_target = 32'sd6553600;
  logic [16:0]        r_dt     = 17'd6554;
  logic [15:0]        r_steps  = 16'd100;

  pin_t                 pinned_q[$];
  satmp_pkg::out_item_t predicted_states[$];
  int        n_sent = 0;
  int        n_got = 0;
  int        mismatches = 0;
  logic      calm = 1'b0;
  logic      hold_req = 1'b0;

  stop_at_target_motion_profile dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [31:0] clamp_q(longint v);
    if (v > SAT_HI) return Q_MAX;
    if (v < SAT_LO) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic satmp_pkg::out_item_t next_motion(satmp_pkg::in_item_t it);
    longint               remain, dt, dv, v_new, x_new;
    longint unsigned      mag, den;
    logic                 stop_now;
    logic signed [31:0]   a_new;
    logic [1:0]           mode_new;
    satmp_pkg::out_item_t r;
    r.last_step = 1'b0;
    if (it.opcode == satmp_pkg::OP_LOAD) begin
      m_mode  = (it.init_mode == satmp_pkg::MODE_NONE) ? satmp_pkg::MODE_CON : it.init_mode;
      m_pos   = it.init_position;
      m_spd   = it.init_speed;
      m_acc   = it.init_accel;
      m_ticks = '0;
    end else begin
      remain = longint'(r_target) - longint'(m_pos);
      mag = (m_spd < 0) ? -longint'(m_spd) : longint'(m_spd);
      // stopping distance v*v / (2*|dec|), floored; none for a non-negative rate
      if (r_dec < 0) begin
        den = -longint'(r_dec);
        stop_now = remain <= longint'((mag * mag) / (den * 2));
      end else begin
        stop_now = remain <= 0;
      end
      if (stop_now) begin
        mode_new = satmp_pkg::MODE_DEC;
      end else if (m_mode == satmp_pkg::MODE_ACC && m_spd >= r_vmax) begin
        mode_new = satmp_pkg::MODE_CON;
      end else begin
        mode_new = m_mode;
      end
      case (m_mode)
        satmp_pkg::MODE_ACC: a_new = r_acc;
        satmp_pkg::MODE_DEC: a_new = r_dec;
        default:             a_new = '0;
      endcase
      dt = r_dt;
      // round to nearest, ties upward
      dv = (longint'(m_acc) * dt + 64'sd32768) >>> 16;
      v_new = clamp_q(longint'(m_spd) + dv);
      x_new = clamp_q(longint'(m_pos) + (((longint'(m_spd) + v_new) * dt + 64'sd65536) >>> 17));
      m_mode = mode_new;
      m_spd  = v_new[31:0];
      m_pos  = x_new[31:0];
      m_acc  = a_new;
      if (m_ticks != 16'hFFFF) begin
        m_ticks++;
        r.last_step = (m_ticks == r_steps);
      end
    end
    r.mode_out     = m_mode;
    r.position_out = m_pos;
    r.speed_out    = m_spd;
    r.accel_out    = m_acc;
    return r;
  endfunction

  function automatic plan_row_t item_row(logic op, logic [1:0] md,
                                         logic [satmp_pkg::Q_W-1:0] p,
                                         logic [satmp_pkg::Q_W-1:0] s,
                                         logic [satmp_pkg::Q_W-1:0] a);
    plan_row_t r;
    r = '{default: '0};
    r.it = satmp_pkg::in_item_t'{op, md, p, s, a};
    return r;
  endfunction

  function automatic plan_row_t pin(plan_row_t r, satmp_pkg::out_item_t w);
    r.pinned = 1'b1;
    r.want   = w;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [satmp_pkg::REG_W-1:0] idx,
                                        logic [satmp_pkg::Q_W-1:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic satmp_pkg::in_item_t noise_item();
    satmp_pkg::in_item_t it;
    it.opcode        = 1'($urandom_range(0, 1));
    it.init_mode     = 2'($urandom_range(0, 3));
    it.init_position = $urandom;
    it.init_speed    = $urandom;
    it.init_accel    = $urandom;
    return it;
  endfunction

  task automatic write_reg(input logic [satmp_pkg::REG_W-1:0] idx,
                           input logic [satmp_pkg::Q_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      satmp_pkg::REG_ACC_RATE:    r_acc    = val;
      satmp_pkg::REG_DEC_RATE:    r_dec    = val;
      satmp_pkg::REG_SPEED_LIMIT: r_vmax   = val;
      satmp_pkg::REG_TARGET_POS:  r_target = val;
      satmp_pkg::REG_TIME_STEP:   r_dt     = val[16:0];
      satmp_pkg::REG_STEP_COUNT:  r_steps  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic send_item(input satmp_pkg::in_item_t it, input logic pinned,
                           input satmp_pkg::out_item_t want);
    if (cfg_valid) cfg_valid <= 1'b0;
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pinned_q = {pinned_q, pin_t'{pinned, want}};
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    n_sent++;
  endtask

  task automatic halt_items();
    if (item_valid) item_valid <= 1'b0;
    while (n_got < n_sent) @(posedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    satmp_pkg::out_item_t want;
    pin_t                 p;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        want = next_motion(item);
        p = pinned_q.pop_front();
        predicted_states = {predicted_states, (p.pinned ? p.want : want)};
      end
      if (result_valid && !result_stall) begin
        n_got++;
        if (predicted_states.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", result);
        end else begin
          want = predicted_states.pop_front();
          if (want.mode_out !== result.mode_out || want.position_out !== result.position_out ||
              want.speed_out !== result.speed_out || want.accel_out !== result.accel_out ||
              want.last_step !== result.last_step) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: expected mode %0d pos %h spd %h acc %h last %b, ",
                       n_got, want.mode_out, want.position_out, want.speed_out,
                       want.accel_out, want.last_step,
                       "got mode %0d pos %h spd %h acc %h last %b",
                       result.mode_out, result.position_out, result.speed_out,
                       result.accel_out, result.last_step);
          end
        end
      end
    end
  end

  initial begin : result_side
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(posedge clk);
          n++;
        end
        result_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    plan_row_t           plan[$];
    satmp_pkg::in_item_t it;
    int        seg;
    logic      held;
    logic      paused;
    seg = 0;
    held = 1'b0;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // first tick after reset only picks up the accelerate rate
    plan = {plan, pin(item_row(satmp_pkg::OP_TICK, satmp_pkg::MODE_ACC, '0, '0, '0),
                      satmp_pkg::out_item_t'{satmp_pkg::MODE_ACC, '0, '0, 32'd1310720, 1'b0})};
    plan = {plan, pin(item_row(satmp_pkg::OP_LOAD, satmp_pkg::MODE_ACC, '0, '0, '0),
                      satmp_pkg::out_item_t'{satmp_pkg::MODE_ACC, '0, '0, '0, 1'b0})};
    repeat (3) plan = {plan, item_row(satmp_pkg::OP_TICK, satmp_pkg::MODE_ACC, '0, '0, '0)};
    // mode code three loads as cruise
    plan = {plan, pin(item_row(satmp_pkg::OP_LOAD, satmp_pkg::MODE_NONE, Q_MAX, Q_MIN, Q_MAX),
                      satmp_pkg::out_item_t'{satmp_pkg::MODE_CON, Q_MAX, Q_MIN, Q_MAX, 1'b0})};
    plan = {plan, item_row(satmp_pkg::OP_TICK, satmp_pkg::MODE_NONE, Q_MAX, Q_MAX, Q_MAX)};
    plan = {plan, pin(item_row(satmp_pkg::OP_LOAD, satmp_pkg::MODE_DEC, Q_MIN, Q_MAX, Q_MAX),
                      satmp_pkg::out_item_t'{satmp_pkg::MODE_DEC, Q_MIN, Q_MAX, Q_MAX, 1'b0})};
    plan = {plan, item_row(satmp_pkg::OP_TICK, satmp_pkg::MODE_ACC, '0, '0, '0)};
    plan = {plan, pin(item_row(satmp_pkg::OP_LOAD, satmp_pkg::MODE_CON, '0, Q_MIN, Q_MIN),
                      satmp_pkg::out_item_t'{satmp_pkg::MODE_CON, '0, Q_MIN, Q_MIN, 1'b0})};
    plan = {plan, item_row(satmp_pkg::OP_TICK, satmp_pkg::MODE_ACC, '0, '0, '0)};
    // zero deceleration, time step above one, flag on the first tick
    plan = {plan, reg_row(satmp_pkg::REG_DEC_RATE, '0)};
    plan = {plan, reg_row(satmp_pkg::REG_TIME_STEP, 32'h0001_FFFF)};
    plan = {plan, reg_row(satmp_pkg::REG_STEP_COUNT, 32'd1)};
    plan = {plan, pin(item_row(satmp_pkg::OP_LOAD, satmp_pkg::MODE_ACC, '0, 32'd327680,
                               32'd65536),
                      satmp_pkg::out_item_t'{satmp_pkg::MODE_ACC, '0, 32'd327680, 32'd65536,
                                             1'b0})};
    repeat (2) plan = {plan, item_row(satmp_pkg::OP_TICK, satmp_pkg::MODE_ACC, '0, '0, '0)};
    // positive deceleration, zero time step, flag never raised
    plan = {plan, reg_row(satmp_pkg::REG_DEC_RATE, Q_MAX)};
    plan = {plan, reg_row(satmp_pkg::REG_TIME_STEP, '0)};
    plan = {plan, reg_row(satmp_pkg::REG_STEP_COUNT, '0)};
    plan = {plan, reg_row(satmp_pkg::REG_ACC_RATE, Q_MIN)};
    plan = {plan, reg_row(satmp_pkg::REG_SPEED_LIMIT, Q_MIN)};
    plan = {plan, reg_row(satmp_pkg::REG_TARGET_POS, Q_MIN)};
    plan = {plan, pin(item_row(satmp_pkg::OP_LOAD, satmp_pkg::MODE_ACC, Q_MAX, Q_MAX, Q_MIN),
                      satmp_pkg::out_item_t'{satmp_pkg::MODE_ACC, Q_MAX, Q_MAX, Q_MIN, 1'b0})};
    repeat (2) plan = {plan, item_row(satmp_pkg::OP_TICK, satmp_pkg::MODE_ACC, '0, '0, '0)};
    // strongest deceleration against the largest speed square
    plan = {plan, reg_row(satmp_pkg::REG_DEC_RATE, Q_MIN)};
    plan = {plan, reg_row(satmp_pkg::REG_TARGET_POS, Q_MAX)};
    plan = {plan, reg_row(satmp_pkg::REG_SPEED_LIMIT, Q_MAX)};
    plan = {plan, reg_row(satmp_pkg::REG_ACC_RATE, Q_MAX)};
    plan = {plan, reg_row(satmp_pkg::REG_TIME_STEP, 32'd65536)};
    plan = {plan, reg_row(satmp_pkg::REG_STEP_COUNT, 32'h0000_FFFF)};
    plan = {plan, pin(item_row(satmp_pkg::OP_LOAD, satmp_pkg::MODE_ACC, '0, Q_MIN, '0),
                      satmp_pkg::out_item_t'{satmp_pkg::MODE_ACC, '0, Q_MIN, '0, 1'b0})};
    repeat (2) plan = {plan, item_row(satmp_pkg::OP_TICK, satmp_pkg::MODE_ACC, '0, '0, '0)};
    // weakest deceleration
    plan = {plan, reg_row(satmp_pkg::REG_DEC_RATE, 32'hFFFF_FFFF)};
    plan = {plan, reg_row(REG_SPARE, 32'hFFFF_FFFF)};
    plan = {plan, pin(item_row(satmp_pkg::OP_LOAD, satmp_pkg::MODE_CON, '0, 32'h7FFF_0000, '0),
                      satmp_pkg::out_item_t'{satmp_pkg::MODE_CON, '0, 32'h7FFF_0000, '0,
                                             1'b0})};
    plan = {plan, item_row(satmp_pkg::OP_TICK, satmp_pkg::MODE_ACC, '0, '0, '0)};

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        halt_items();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].it, plan[i].pinned, plan[i].want);
      end
    end

    while (n_sent < ITEMS) begin
      calm = (n_sent >= CALM_FROM) || ($urandom_range(0, 3) == 0);
      if (seg % 3 == 0) begin
        halt_items();
        if ($urandom_range(0, 5) == 0) begin
          write_reg(satmp_pkg::REG_ACC_RATE, $urandom);
          write_reg(satmp_pkg::REG_DEC_RATE, $urandom);
          write_reg(satmp_pkg::REG_SPEED_LIMIT, $urandom);
          write_reg(satmp_pkg::REG_TARGET_POS, $urandom);
          write_reg(satmp_pkg::REG_TIME_STEP, $urandom);
          write_reg(satmp_pkg::REG_STEP_COUNT, $urandom);
        end else begin
          write_reg(satmp_pkg::REG_ACC_RATE, $urandom_range(32768, 1966080));
          write_reg(satmp_pkg::REG_DEC_RATE, 32'd0 - 32'($urandom_range(32768, 1966080)));
          write_reg(satmp_pkg::REG_SPEED_LIMIT, $urandom_range(65536, 2621440));
          write_reg(satmp_pkg::REG_TARGET_POS, $urandom_range(655360, 13107200));
          write_reg(satmp_pkg::REG_TIME_STEP,
                    ($urandom & 32'hFFFE_0000) | $urandom_range(1638, 32768));
          write_reg(satmp_pkg::REG_STEP_COUNT,
                    ($urandom & 32'hFFFF_0000) | $urandom_range(1, 40));
        end
        if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, $urandom);
      end
      if (!held && n_sent >= 150) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (!paused && n_sent >= 320) begin
        halt_items();
        paused = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        it = noise_item();
      end else begin
        it.opcode        = satmp_pkg::OP_LOAD;
        it.init_mode     = ($urandom_range(0, 3) != 0) ? satmp_pkg::MODE_ACC
                                                       : 2'($urandom_range(0, 2));
        it.init_position = 32'($urandom_range(0, 2621440)) - 32'd1310720;
        it.init_speed    = $urandom_range(0, 327680);
        it.init_accel    = ($urandom_range(0, 1) == 0) ? '0 : 32'($urandom_range(0, 655360));
      end
      send_item(it, 1'b0, '0);
      repeat ($urandom_range(6, 40)) begin
        if ($urandom_range(0, 24) == 0) begin
          it = noise_item();
        end else begin
          it = noise_item();
          it.opcode = satmp_pkg::OP_TICK;
        end
        send_item(it, 1'b0, '0);
      end
      seg++;
    end

    halt_items();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_states.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
